// File: src/fnorm_pkg.sv
package fnorm_pkg;

	// command codes carried in tuser of the input channel
	localparam logic [1:0] CMD_VWRITE = 2'd0;
	localparam logic [1:0] CMD_FACE   = 2'd1;
	localparam logic [1:0] CMD_NREAD  = 2'd2;

	// classified operations handed from front to back
	localparam logic [1:0] OP_VWRITE = 2'd0;
	localparam logic [1:0] OP_FACE   = 2'd1;
	localparam logic [1:0] OP_NREAD  = 2'd2;
	localparam logic [1:0] OP_BAD    = 2'd3;

	localparam int IDX_W = 16;
	localparam logic [15:0] NORM_ONE = 16'd16384;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] ia;
		logic [IDX_W-1:0] ib;
		logic [IDX_W-1:0] ic;
		logic [15:0]      x;
		logic [15:0]      y;
		logic [15:0]      z;
	} fnorm_req_t;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degenerate;
		logic        bad_index;
	} fnorm_res_t;

endpackage

// File: src/fnorm_front.sv
module fnorm_front #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [111:0]         s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 busy,
	output logic                 q_valid,
	output fnorm_pkg::fnorm_req_t q_req,
	input  logic                 q_pop
);
	import fnorm_pkg::*;

	logic [9:0]  slot;
	logic [15:0] ca, cb, cc;
	logic        slot_ok, corners_ok, push;
	logic        accept;
	fnorm_req_t  req;

	fnorm_req_t  fifo_q [2];
	logic        wptr_q, rptr_q;
	logic [1:0]  count_q;

	assign slot = s_tdata[9:0];
	assign ca   = s_tdata[73:58];
	assign cb   = s_tdata[89:74];
	assign cc   = s_tdata[105:90];

	assign slot_ok = {7'b0, slot} < 17'(VERTEX_DEPTH);
	assign corners_ok = (ca != 16'd0) && (cb != 16'd0) && (cc != 16'd0) &&
		({1'b0, ca} <= 17'(VERTEX_DEPTH)) && ({1'b0, cb} <= 17'(VERTEX_DEPTH)) &&
		({1'b0, cc} <= 17'(VERTEX_DEPTH));

	always_comb begin
		req.op = OP_BAD;
		req.ia = {6'b0, slot};
		req.ib = {6'b0, slot};
		req.ic = {6'b0, slot};
		req.x  = s_tdata[25:10];
		req.y  = s_tdata[41:26];
		req.z  = s_tdata[57:42];
		push   = 1'b0;
		case (s_tuser)
			CMD_VWRITE: begin
				req.op = OP_VWRITE;
				push   = slot_ok;
			end
			CMD_FACE: begin
				req.op = corners_ok ? OP_FACE : OP_BAD;
				req.ia = ca - 16'd1;
				req.ib = cb - 16'd1;
				req.ic = cc - 16'd1;
				push   = 1'b1;
			end
			CMD_NREAD: begin
				req.op = slot_ok ? OP_NREAD : OP_BAD;
				push   = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign s_tready = !busy && (count_q != 2'd2);
	assign accept   = s_tvalid && s_tready;
	assign q_valid  = count_q != 2'd0;
	assign q_req    = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (accept && push) begin
			fifo_q[wptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (accept && push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(accept && push) - 2'(q_pop);
		end
	end

endmodule

// File: src/fnorm_back.sv
module fnorm_back #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  fnorm_pkg::fnorm_req_t q_req,
	output logic                  q_pop,
	output logic                  busy,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output fnorm_pkg::fnorm_res_t m_res
);
	import fnorm_pkg::*;

	localparam int AW = $clog2(VERTEX_DEPTH);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_VWR  = 5'd2;
	localparam logic [4:0] S_NRD  = 5'd3;
	localparam logic [4:0] S_NRW  = 5'd4;
	localparam logic [4:0] S_FA   = 5'd5;
	localparam logic [4:0] S_FB   = 5'd6;
	localparam logic [4:0] S_FC   = 5'd7;
	localparam logic [4:0] S_FD   = 5'd8;
	localparam logic [4:0] S_MUL  = 5'd9;
	localparam logic [4:0] S_CHK  = 5'd10;
	localparam logic [4:0] S_NORM = 5'd11;
	localparam logic [4:0] S_SQ   = 5'd12;
	localparam logic [4:0] S_RT   = 5'd13;
	localparam logic [4:0] S_DIV  = 5'd14;
	localparam logic [4:0] S_FIN  = 5'd15;
	localparam logic [4:0] S_NW0  = 5'd16;
	localparam logic [4:0] S_NW1  = 5'd17;
	localparam logic [4:0] S_NW2  = 5'd18;
	localparam logic [4:0] S_EMIT = 5'd19;

	logic [4:0]    state_q;
	logic [4:0]    cnt_q;
	logic [AW-1:0] clr_q;
	fnorm_req_t    req_q;
	fnorm_res_t    res_q;
	fnorm_res_t    out_q;
	logic          out_valid_q;

	logic [47:0] vmem [VERTEX_DEPTH];
	logic [47:0] nmem [VERTEX_DEPTH];
	logic [47:0] vrd_q, nrd_q;
	logic [AW-1:0] vaddr, naddr;
	logic          vwe, nwe;
	logic [47:0]   nwd;

	logic [47:0]        a_q;
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [34:0] c_q [3];
	logic [33:0]        m_q [3];
	logic [49:0]        s_q;
	logic [61:0]        rad_q;
	logic [33:0]        rem_q;
	logic [30:0]        root_q;
	logic [45:0]        dv_q;
	logic [44:0]        drem_q [3];
	logic [15:0]        quo_q [3];

	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod;
	logic [33:0]        mag [3];
	logic               cross_zero, any_hi, any_mid;
	logic [23:0]        sq_in;
	logic [47:0]        sq;
	logic [49:0]        s_nxt;
	logic [33:0]        rem2, trial;
	logic               rt_ge;
	logic [30:0]        root_nxt;
	logic               emit_go;

	// shared multiplier for the cross product
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
		endcase
	end
	assign prod = mul_a * mul_b;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag[j] = c_q[j][34] ? 34'(-c_q[j]) : 34'(c_q[j]);
		end
	end
	assign cross_zero = (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
	assign any_hi  = (m_q[0][33:24] != '0) || (m_q[1][33:24] != '0) || (m_q[2][33:24] != '0);
	assign any_mid = m_q[0][23] || m_q[1][23] || m_q[2][23];

	assign sq_in = m_q[cnt_q[1:0]][23:0];
	assign sq    = sq_in * sq_in;
	assign s_nxt = s_q + 50'(sq);

	// one root bit per cycle
	assign rem2     = {rem_q[31:0], rad_q[61:60]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign rt_ge    = rem2 >= trial;
	assign root_nxt = {root_q[29:0], rt_ge};

	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || m_tready);
	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign busy    = state_q == S_CLR;

	// memory ports
	always_comb begin
		case (state_q)
			S_FB:    vaddr = req_q.ib[AW-1:0];
			S_FC:    vaddr = req_q.ic[AW-1:0];
			default: vaddr = req_q.ia[AW-1:0];
		endcase
		case (state_q)
			S_CLR:   naddr = clr_q;
			S_NW1:   naddr = req_q.ib[AW-1:0];
			S_NW2:   naddr = req_q.ic[AW-1:0];
			default: naddr = req_q.ia[AW-1:0];
		endcase
	end
	assign vwe = state_q == S_VWR;
	assign nwe = (state_q == S_CLR) || (state_q == S_NW0) || (state_q == S_NW1) ||
		(state_q == S_NW2);
	assign nwd = (state_q == S_CLR) ? 48'd0 : {res_q.nz, res_q.ny, res_q.nx};

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vaddr] <= {req_q.z, req_q.y, req_q.x};
		end
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (nwe) begin
			nmem[naddr] <= nwd;
		end
		nrd_q <= nmem[naddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= 5'd0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(VERTEX_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_req.op)
							OP_VWRITE: state_q <= S_VWR;
							OP_FACE:   state_q <= S_FA;
							OP_NREAD:  state_q <= S_NRD;
							default:   state_q <= S_EMIT;
						endcase
					end
				end
				S_VWR: state_q <= S_IDLE;
				S_NRD: state_q <= S_NRW;
				S_NRW: state_q <= S_EMIT;
				S_FA:  state_q <= S_FB;
				S_FB:  state_q <= S_FC;
				S_FC:  state_q <= S_FD;
				S_FD: begin
					cnt_q   <= 5'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd5) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= cross_zero ? S_NW0 : S_NORM;
				S_NORM: begin
					if (!any_hi && any_mid) begin
						cnt_q   <= 5'd0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						cnt_q   <= 5'd30;
						state_q <= S_RT;
					end
				end
				S_RT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						cnt_q   <= 5'd15;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_NW0;
				S_NW0: state_q <= S_NW1;
				S_NW1: state_q <= S_NW2;
				S_NW2: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				req_q           <= q_req;
				res_q.nx        <= '0;
				res_q.ny        <= '0;
				res_q.nz        <= '0;
				res_q.degenerate <= 1'b0;
				res_q.bad_index <= 1'b1;
			end
			S_NRW: begin
				res_q.nx        <= nrd_q[15:0];
				res_q.ny        <= nrd_q[31:16];
				res_q.nz        <= nrd_q[47:32];
				res_q.degenerate <= 1'b0;
				res_q.bad_index <= 1'b0;
			end
			S_FB: a_q <= vrd_q;
			S_FC: begin
				for (int j = 0; j < 3; j++) begin
					e1_q[j] <= $signed({vrd_q[16*j+15], vrd_q[16*j +: 16]}) -
						$signed({a_q[16*j+15], a_q[16*j +: 16]});
				end
			end
			S_FD: begin
				for (int j = 0; j < 3; j++) begin
					e2_q[j] <= $signed({vrd_q[16*j+15], vrd_q[16*j +: 16]}) -
						$signed({a_q[16*j+15], a_q[16*j +: 16]});
				end
			end
			S_MUL: begin
				c_q[cnt_q[2:1]] <= cnt_q[0] ? c_q[cnt_q[2:1]] - 35'(prod) : 35'(prod);
			end
			S_CHK: begin
				for (int j = 0; j < 3; j++) begin
					m_q[j] <= mag[j];
				end
				res_q.nx        <= '0;
				res_q.ny        <= '0;
				res_q.nz        <= '0;
				res_q.degenerate <= cross_zero;
				res_q.bad_index <= 1'b0;
				s_q             <= '0;
			end
			S_NORM: begin
				// bring the largest magnitude into [2^23, 2^24)
				for (int j = 0; j < 3; j++) begin
					if (any_hi) begin
						m_q[j] <= m_q[j] >> 1;
					end else if (!any_mid) begin
						m_q[j] <= m_q[j] << 1;
					end
				end
			end
			S_SQ: begin
				s_q <= s_nxt;
				if (cnt_q == 5'd2) begin
					rad_q  <= {s_nxt, 12'b0};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			S_RT: begin
				rem_q  <= rt_ge ? rem2 - trial : rem2;
				root_q <= root_nxt;
				rad_q  <= rad_q << 2;
				if (cnt_q == 5'd0) begin
					dv_q <= {root_nxt, 15'b0};
					for (int j = 0; j < 3; j++) begin
						drem_q[j] <= {m_q[j][23:0], 20'b0} + 45'(root_nxt[30:1]);
						quo_q[j]  <= '0;
					end
				end
			end
			S_DIV: begin
				for (int j = 0; j < 3; j++) begin
					if ({1'b0, drem_q[j]} >= dv_q) begin
						drem_q[j] <= 45'({1'b0, drem_q[j]} - dv_q);
						quo_q[j]  <= {quo_q[j][14:0], 1'b1};
					end else begin
						quo_q[j] <= {quo_q[j][14:0], 1'b0};
					end
				end
				dv_q <= dv_q >> 1;
			end
			S_FIN: begin
				res_q.nx <= c_q[0][34] ? -((quo_q[0] > NORM_ONE) ? NORM_ONE : quo_q[0]) :
					((quo_q[0] > NORM_ONE) ? NORM_ONE : quo_q[0]);
				res_q.ny <= c_q[1][34] ? -((quo_q[1] > NORM_ONE) ? NORM_ONE : quo_q[1]) :
					((quo_q[1] > NORM_ONE) ? NORM_ONE : quo_q[1]);
				res_q.nz <= c_q[2][34] ? -((quo_q[2] > NORM_ONE) ? NORM_ONE : quo_q[2]) :
					((quo_q[2] > NORM_ONE) ? NORM_ONE : quo_q[2]);
				res_q.degenerate <= 1'b0;
				res_q.bad_index <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_res    = out_q;

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !out_valid_q)
		else $error("result presented during normal store clear");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad_index) |->
		(out_q.nx == '0 && out_q.ny == '0 && out_q.nz == '0 && !out_q.degenerate))
		else $error("bad index result carries data");

	a_degenerate_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.degenerate) |->
		(out_q.nx == '0 && out_q.ny == '0 && out_q.nz == '0))
		else $error("degenerate result carries a nonzero normal");

	a_normal_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |->
		($signed(out_q.nx) <= 16'sd16384 && $signed(out_q.nx) >= -16'sd16384 &&
		 $signed(out_q.ny) <= 16'sd16384 && $signed(out_q.ny) >= -16'sd16384 &&
		 $signed(out_q.nz) <= 16'sd16384 && $signed(out_q.nz) >= -16'sd16384))
		else $error("normal component beyond unit length");

endmodule

// File: src/triangle_face_normal_engine.sv
// Triangle face normal engine.
// Input stream (s_*): one request per accepted beat. tuser is the command:
// vertex write, face normal, or stored-normal read. tdata carries the slot,
// the Q8.8 coordinates and the three one-based face corners.
// Output stream (m_*): one result per face or read request, none for a vertex
// write. tdata holds the Q1.14 normal, tuser the degenerate and bad index flags.
// Requests pass through a two-entry queue into a sequencer that owns the vertex
// and normal memories and works one request at a time.
// A face goes through three vertex reads, six cross-product multiplies on one
// shared multiplier, up to 23 normalizing shifts, a 31-step square root and a
// 16-step divider running three lanes, then three normal-store writes; a
// degenerate face skips the shifts, square root and divider.
// Throughput is set by the square root and divider loops for faces.
// After reset the normal store is cleared one entry per cycle, all VERTEX_DEPTH
// entries, with s_tready low. A stalled m_tready holds the result in the output
// register; requests are still accepted meanwhile until the sequencer waits with
// a second result and the queue holds two.
module triangle_face_normal_engine #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vertex_slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, zero fill
	input  logic [111:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z
	output logic [47:0]  m_tdata,
	// degenerate, bad_index
	output logic [1:0]   m_tuser
);
	import fnorm_pkg::*;

	fnorm_req_t q_req;
	fnorm_res_t res;
	logic       q_valid, q_pop, busy;

	fnorm_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.busy     (busy),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	fnorm_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res)
	);

	assign m_tdata = {res.nz, res.ny, res.nx};
	assign m_tuser = {res.bad_index, res.degenerate};

endmodule

// File: dv/triangle_face_normal_engine_compare.sv
`timescale 1ns / 100ps

module triangle_face_normal_engine_compare (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending
);
	import fnorm_pkg::*;

	localparam int DEPTH = 1024;

	logic signed [15:0] vert_x [DEPTH];
	logic signed [15:0] vert_y [DEPTH];
	logic signed [15:0] vert_z [DEPTH];
	logic signed [15:0] norm_x [DEPTH];
	logic signed [15:0] norm_y [DEPTH];
	logic signed [15:0] norm_z [DEPTH];

	fnorm_res_t expected_normals [$];

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// predict the result of one request and update the stores
	function automatic fnorm_res_t predict_normal(input logic [1:0] cmd,
		input logic [111:0] data);
		fnorm_res_t res;
		int slot, ia, ib, ic, k;
		int unsigned ca, cb, cc;
		longint e1x, e1y, e1z, e2x, e2y, e2z;
		longint c [3];
		longint unsigned m [3];
		longint unsigned big, s, r, q;
		logic signed [15:0] n [3];
		res = '0;
		slot = int'(data[9:0]);
		ca = 32'(data[73:58]);
		cb = 32'(data[89:74]);
		cc = 32'(data[105:90]);
		if (cmd == CMD_NREAD) begin
			res.nx = norm_x[slot];
			res.ny = norm_y[slot];
			res.nz = norm_z[slot];
			return res;
		end
		if (ca == 0 || cb == 0 || cc == 0 || ca > DEPTH || cb > DEPTH || cc > DEPTH) begin
			res.bad_index = 1'b1;
			return res;
		end
		ia = ca - 1;
		ib = cb - 1;
		ic = cc - 1;
		e1x = longint'(vert_x[ib]) - vert_x[ia];
		e1y = longint'(vert_y[ib]) - vert_y[ia];
		e1z = longint'(vert_z[ib]) - vert_z[ia];
		e2x = longint'(vert_x[ic]) - vert_x[ia];
		e2y = longint'(vert_y[ic]) - vert_y[ia];
		e2z = longint'(vert_z[ic]) - vert_z[ia];
		c[0] = e1y * e2z - e1z * e2y;
		c[1] = e1z * e2x - e1x * e2z;
		c[2] = e1x * e2y - e1y * e2x;
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
			n[0] = 0;
			n[1] = 0;
			n[2] = 0;
			res.degenerate = 1'b1;
		end else begin
			for (k = 0; k < 3; k++) m[k] = c[k] < 0 ? longint'(-c[k]) : c[k];
			big = m[0];
			if (m[1] > big) big = m[1];
			if (m[2] > big) big = m[2];
			while (big < (64'd1 << 23)) begin
				big <<= 1;
				for (k = 0; k < 3; k++) m[k] <<= 1;
			end
			while (big >= (64'd1 << 24)) begin
				big >>= 1;
				for (k = 0; k < 3; k++) m[k] >>= 1;
			end
			s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			r = int_sqrt(s << 12);
			if (r == 0) r = 1;
			for (k = 0; k < 3; k++) begin
				q = ((m[k] << 20) + (r >> 1)) / r;
				if (q > NORM_ONE) q = NORM_ONE;
				n[k] = c[k] < 0 ? -16'(q) : 16'(q);
			end
		end
		norm_x[ia] = n[0]; norm_y[ia] = n[1]; norm_z[ia] = n[2];
		norm_x[ib] = n[0]; norm_y[ib] = n[1]; norm_z[ib] = n[2];
		norm_x[ic] = n[0]; norm_y[ic] = n[1]; norm_z[ic] = n[2];
		res.nx = n[0];
		res.ny = n[1];
		res.nz = n[2];
		return res;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		for (int i = 0; i < DEPTH; i++) begin
			vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
			norm_x[i] = 0; norm_y[i] = 0; norm_z[i] = 0;
		end
	end

	always @(posedge clk) begin
		fnorm_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_normals.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
			end else begin
				want = expected_normals.pop_front();
				if (m_tdata[15:0] !== want.nx || m_tdata[31:16] !== want.ny ||
						m_tdata[47:32] !== want.nz || m_tuser[0] !== want.degenerate ||
						m_tuser[1] !== want.bad_index) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected n=(%0d,%0d,%0d) deg %b bad %b,",
							$signed(want.nx), $signed(want.ny), $signed(want.nz),
							want.degenerate, want.bad_index,
							" got n=(%0d,%0d,%0d) deg %b bad %b",
							$signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
							$signed(m_tdata[47:32]), m_tuser[0], m_tuser[1]);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			if (s_tuser == CMD_VWRITE) begin
				vert_x[s_tdata[9:0]] = s_tdata[25:10];
				vert_y[s_tdata[9:0]] = s_tdata[41:26];
				vert_z[s_tdata[9:0]] = s_tdata[57:42];
			end else if (s_tuser == CMD_FACE || s_tuser == CMD_NREAD) begin
				want = predict_normal(s_tuser, s_tdata);
				expected_normals = {expected_normals, want};
			end
		end
		pending = expected_normals.size();
	end

endmodule

// File: dv/triangle_face_normal_engine_test.sv
`timescale 1ns / 100ps

module triangle_face_normal_engine_test;
	import fnorm_pkg::*;

	localparam int DEPTH = 1024;
	localparam int RANDOM_ITEMS = 2000;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 600;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = CMD_VWRITE;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           errors, pending;

	int           send_idle_pct = 29;
	int           recv_idle_pct = 60;
	bit           hold_go = 1'b0;
	bit           hold_seen = 1'b0;
	int           hold_off = 0;
	longint       cycles = 0;
	bit           written [DEPTH];
	int           written_slots [$];

	always #6 clk = ~clk;

	triangle_face_normal_engine dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	triangle_face_normal_engine_compare compare (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("triangle_face_normal_engine test failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off when requested
	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_off <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_request(input logic [1:0] cmd, input logic [111:0] data);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd == CMD_VWRITE && !written[data[9:0]]) begin
			written[data[9:0]] = 1'b1;
			written_slots = {written_slots, int'(data[9:0])};
		end
	endtask

	function automatic logic [111:0] vertex_data(input logic [9:0] slot,
		input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		return {54'd0, z, y, x, slot};
	endfunction

	function automatic logic [111:0] face_data(input logic [15:0] a,
		input logic [15:0] b, input logic [15:0] c);
		return {6'd0, c, b, a, 58'd0};
	endfunction

	function automatic logic [15:0] random_coord();
		if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
		return 16'($signed($urandom_range(0, 2047)) - 1024);
	endfunction

	function automatic logic [15:0] written_corner();
		return 16'(written_slots[$urandom_range(0, written_slots.size() - 1)] + 1);
	endfunction

	task automatic random_request();
		int pick;
		logic [9:0] slot;
		logic [15:0] a, b, c;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			slot = $urandom_range(0, 99) < 80 ? 10'($urandom_range(0, 63))
				: 10'($urandom_range(0, DEPTH - 1));
			send_request(CMD_VWRITE, vertex_data(slot, random_coord(), random_coord(),
				random_coord()));
		end else if (pick < 72) begin
			a = written_corner();
			b = written_corner();
			c = $urandom_range(0, 9) == 0 ? a : written_corner();
			send_request(CMD_FACE, face_data(a, b, c));
		end else if (pick < 78) begin
			// at least one corner out of range so no unwritten vertex is read
			c = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(DEPTH + 1, 65535));
			a = 16'($urandom_range(0, 65535));
			b = 16'($urandom_range(0, 65535));
			case ($urandom_range(0, 2))
				0: send_request(CMD_FACE, face_data(a, b, c));
				1: send_request(CMD_FACE, face_data(c, a, b));
				default: send_request(CMD_FACE, face_data(b, c, a));
			endcase
		end else if (pick < 96) begin
			slot = $urandom_range(0, 1) ? 10'(written_corner() - 16'd1)
				: 10'($urandom_range(0, DEPTH - 1));
			send_request(CMD_NREAD, {102'd0, slot});
		end else begin
			send_request(CMD_UNUSED, {$urandom, $urandom, $urandom, 16'($urandom)});
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme coordinates, bad corners, a degenerate face, reads
		send_request(CMD_VWRITE, vertex_data(10'd0, 16'h8000, 16'h8000, 16'h8000));
		send_request(CMD_VWRITE, vertex_data(10'd1023, 16'h7fff, 16'h7fff, 16'h8000));
		send_request(CMD_VWRITE, vertex_data(10'd1, 16'h7fff, 16'h8000, 16'h7fff));
		send_request(CMD_VWRITE, vertex_data(10'd2, 16'h0000, 16'h0000, 16'h0000));
		send_request(CMD_VWRITE, vertex_data(10'd3, 16'h0100, 16'h0000, 16'h0000));
		send_request(CMD_VWRITE, vertex_data(10'd4, 16'h0000, 16'h0100, 16'h0000));
		send_request(CMD_VWRITE, vertex_data(10'd5, 16'h0200, 16'h0000, 16'h0000));
		send_request(CMD_VWRITE, vertex_data(10'd6, 16'h0000, 16'h0000, 16'h0001));
		send_request(CMD_NREAD, {102'd0, 10'd3});
		send_request(CMD_FACE, face_data(16'd1, 16'd1024, 16'd2));
		send_request(CMD_FACE, face_data(16'd3, 16'd4, 16'd5));
		send_request(CMD_FACE, face_data(16'd3, 16'd4, 16'd7));
		send_request(CMD_FACE, face_data(16'd3, 16'd5, 16'd6));
		send_request(CMD_FACE, face_data(16'd3, 16'd3, 16'd4));
		send_request(CMD_FACE, face_data(16'd0, 16'd4, 16'd5));
		send_request(CMD_FACE, face_data(16'd3, 16'd1025, 16'd5));
		send_request(CMD_FACE, face_data(16'd3, 16'd4, 16'hffff));
		send_request(CMD_NREAD, {102'd0, 10'd0});
		send_request(CMD_NREAD, {102'd0, 10'd1023});
		send_request(CMD_NREAD, {102'd0, 10'd2});
		send_request(CMD_NREAD, {102'd0, 10'd500});
		send_request(CMD_UNUSED, {112{1'b1}});

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 60;
				recv_idle_pct = 29;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_go <= 1'b1;
			end
			random_request();
		end
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("triangle_face_normal_engine test passed");
		else
			$display("triangle_face_normal_engine test failed");
		$finish;
	end

endmodule

// File: triangle_face_normal_engine.f
src/fnorm_pkg.sv
src/fnorm_front.sv
src/fnorm_back.sv
src/triangle_face_normal_engine.sv
dv/triangle_face_normal_engine_compare.sv
dv/triangle_face_normal_engine_test.sv
